// ===== rtl/whp_pkg.sv =====
// Shared types and constants for the WAV header parser.
`default_nettype none

package whp_pkg;

  // Width of the packed result beat, rounded up to whole bytes.
  localparam int unsigned ResultBits = 97;
  localparam int unsigned OutDataW   = ((ResultBits + 7) / 8) * 8;

  // Four-character tags as they read from a little-endian 32-bit field.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE       = 32'd16;
  localparam logic [15:0] FMT_PCM        = 16'd1;
  localparam logic [15:0] CHAN_MONO      = 16'd1;
  localparam logic [15:0] CHAN_STEREO    = 16'd2;
  localparam logic [15:0] UNSIGNED_DEPTH = 16'd8;

  // Header byte positions on which a field completes.
  localparam logic [5:0] POS_RIFF     = 6'd3;
  localparam logic [5:0] POS_WAVE     = 6'd11;
  localparam logic [5:0] POS_FMT      = 6'd15;
  localparam logic [5:0] POS_FMT_SIZE = 6'd19;
  localparam logic [5:0] POS_FORMAT   = 6'd21;
  localparam logic [5:0] POS_CHANNELS = 6'd23;
  localparam logic [5:0] POS_RATE     = 6'd27;
  localparam logic [5:0] POS_BYTERATE = 6'd31;
  localparam logic [5:0] POS_ALIGN_LO = 6'd32;
  localparam logic [5:0] POS_ALIGN_HI = 6'd33;
  localparam logic [5:0] POS_DEPTH    = 6'd35;
  localparam logic [5:0] POS_DATA     = 6'd39;
  localparam logic [5:0] POS_LAST     = 6'd43;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_PARSING  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_ERROR    = 2'd2,
    ST_PAYLOAD  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_RIFF     = 4'd1,
    ERR_WAVE     = 4'd2,
    ERR_FMT      = 4'd3,
    ERR_FMT_SIZE = 4'd4,
    ERR_NOT_PCM  = 4'd5,
    ERR_CHANNELS = 4'd6,
    ERR_BYTERATE = 4'd7,
    ERR_DATA     = 4'd8
  } err_t;

  // One result item as produced for one input byte.
  typedef struct packed {
    logic [31:0] data_length;
    logic        samples_signed;
    logic [1:0]  channel_count;
    logic [15:0] bit_depth;
    logic [31:0] sample_rate;
    logic [7:0]  payload_byte;
    logic [3:0]  error_code;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/whp_parse.sv =====
// Header parsing state and the per-byte result logic of the WAV header parser.
`default_nettype none

module whp_parse
  import whp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] byte_in,
  input  wire logic       restart,
  output result_t         res
);

  logic [5:0]  pos_r, pos_nxt, pos_eff;
  phase_t      phase_r, phase_nxt, phase_eff;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] byte_rate_r, byte_rate_nxt;
  logic [31:0] diff_r, diff_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [1:0]  chan_r, chan_nxt;
  logic [31:0] length_r, length_nxt;
  err_t        error_r, error_nxt;
  err_t        err_now;
  logic [15:0] v16;
  logic [39:0] prod;

  // A restart beat parses as byte 0 of a fresh header.
  assign pos_eff   = restart ? '0 : pos_r;
  assign phase_eff = restart ? PH_HEADER : phase_r;
  assign shift_nxt = {byte_in, shift_r[31:8]};
  assign v16       = shift_nxt[31:16];

  // Rate times one block-align byte; shared by both block-align beats.
  assign prod = {8'd0, rate_r} * {32'd0, byte_in};

  // Field checks and captures on the byte that completes each field.
  // Only header bytes are checked; payload and error bytes leave the fields alone.
  always_comb begin
    err_now       = ERR_NONE;
    rate_nxt      = rate_r;
    byte_rate_nxt = byte_rate_r;
    diff_nxt      = diff_r;
    depth_nxt     = depth_r;
    chan_nxt      = chan_r;
    length_nxt    = length_r;
    if (phase_eff == PH_HEADER) begin
      case (pos_eff)
        POS_RIFF:     if (shift_nxt != TAG_RIFF) err_now = ERR_RIFF;
        POS_WAVE:     if (shift_nxt != TAG_WAVE) err_now = ERR_WAVE;
        POS_FMT:      if (shift_nxt != TAG_FMT) err_now = ERR_FMT;
        POS_FMT_SIZE: if (shift_nxt != FMT_SIZE) err_now = ERR_FMT_SIZE;
        POS_FORMAT:   if (v16 != FMT_PCM) err_now = ERR_NOT_PCM;
        POS_CHANNELS: begin
          if (v16 != CHAN_MONO && v16 != CHAN_STEREO) err_now = ERR_CHANNELS;
          chan_nxt = v16[1:0];
        end
        POS_RATE:     rate_nxt = shift_nxt;
        POS_BYTERATE: byte_rate_nxt = shift_nxt;
        // Byte rate must equal rate * (lo + 256 * hi) modulo 2^32; the low
        // partial product is taken off first, the high one is compared next.
        POS_ALIGN_LO: diff_nxt = byte_rate_r - prod[31:0];
        POS_ALIGN_HI: if (diff_r != {prod[23:0], 8'h00}) err_now = ERR_BYTERATE;
        POS_DEPTH:    depth_nxt = v16;
        POS_DATA:     if (shift_nxt != TAG_DATA) err_now = ERR_DATA;
        POS_LAST:     length_nxt = shift_nxt;
        default:      err_now = ERR_NONE;
      endcase
    end
  end

  // Next phase, position and latched error.
  always_comb begin
    phase_nxt = phase_eff;
    pos_nxt   = pos_eff;
    error_nxt = restart ? ERR_NONE : error_r;
    unique case (phase_eff)
      PH_HEADER: begin
        if (err_now != ERR_NONE) begin
          phase_nxt = PH_ERROR;
          error_nxt = err_now;
        end else if (pos_eff == POS_LAST) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          pos_nxt = pos_eff + 6'd1;
        end
      end
      PH_PAYLOAD: phase_nxt = PH_PAYLOAD;
      PH_ERROR:   phase_nxt = PH_ERROR;
      default:    phase_nxt = PH_ERROR;
    endcase
  end

  // Result of this byte.
  always_comb begin
    status_t st;
    logic    show;
    st   = ST_ERROR;
    show = 1'b0;
    unique case (phase_eff)
      PH_HEADER: begin
        if (err_now != ERR_NONE) begin
          st = ST_ERROR;
        end else if (pos_eff == POS_LAST) begin
          st   = ST_ACCEPTED;
          show = 1'b1;
        end else begin
          st = ST_PARSING;
        end
      end
      PH_PAYLOAD: begin
        st   = ST_PAYLOAD;
        show = 1'b1;
      end
      PH_ERROR:   st = ST_ERROR;
      default:    st = ST_ERROR;
    endcase
    res.status         = st;
    res.error_code     = (st == ST_ERROR) ? error_nxt : ERR_NONE;
    res.payload_byte   = (st == ST_PAYLOAD) ? byte_in : 8'd0;
    res.sample_rate    = show ? rate_r : 32'd0;
    res.bit_depth      = show ? depth_r : 16'd0;
    res.channel_count  = show ? chan_r : 2'd0;
    res.samples_signed = show && (depth_r != UNSIGNED_DEPTH);
    res.data_length    = show ? length_nxt : 32'd0;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      error_r <= ERR_NONE;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      error_r <= error_nxt;
    end
  end

  // Field registers; every one is rewritten before it is shown.
  always_ff @(posedge clk) begin
    if (accept) begin
      shift_r     <= shift_nxt;
      rate_r      <= rate_nxt;
      byte_rate_r <= byte_rate_nxt;
      diff_r      <= diff_nxt;
      depth_r     <= depth_nxt;
      chan_r      <= chan_nxt;
      length_r    <= length_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wav_header_parser.sv =====
// Top level of the WAV header parser: stream handshake and result register.
//
//  Channel  Ports                  Beat contents
//  input    in_tvalid/tready       in_tdata: byte_in; in_tuser: restart
//  result   out_tvalid/tready      out_tdata: status, error_code, payload_byte,
//                                  sample_rate, bit_depth, channel_count,
//                                  samples_signed, data_length
//
// One input beat gives one result beat; a beat is taken every cycle unless the output is stalled.
// The result appears in the cycle after its input beat, from the output register.
// A new beat is taken while the held result is being read out in that cycle.
// Reset clears the parse position, phase, error and the output valid.
// A stalled output holds its beat and stops the input.
`default_nettype none

module wav_header_parser
  import whp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,   // byte_in [7:0]
  input  wire logic                in_tuser,   // restart [0]
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata   // status, error_code, payload_byte,
                                               // sample_rate, bit_depth,
                                               // channel_count, samples_signed,
                                               // data_length, zero pad
);

  result_t                res;
  logic                   accept;
  logic                   valid_r;
  logic [OutDataW-1:0]    data_r;

  assign in_tready = !valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  whp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .byte_in (in_tdata),
    .restart (in_tuser),
    .res     (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= {{(OutDataW - ResultBits){1'b0}}, res};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

`default_nettype wire

// ===== rtl/whp_checker.sv =====
// Port-level checks for the WAV header parser and their bind.
`default_nettype none

module whp_checker
  import whp_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata
);

  logic [1:0] st;
  logic [3:0] ec;
  logic [1:0] ch;

  assign st = out_tdata[1:0];
  assign ec = out_tdata[5:2];
  assign ch = out_tdata[63:62];

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Error codes appear only with the error status.
  a_err_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_ERROR |-> ec == ERR_NONE)
    else $error("error code without error status");

  // An error status always carries a known error code.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_ERROR |-> ec != ERR_NONE && ec <= ERR_DATA)
    else $error("error status without a valid code");

  // Accepted headers and payload beats report one or two channels.
  a_channels: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_ACCEPTED || st == ST_PAYLOAD) |-> ch == 2'd1 || ch == 2'd2)
    else $error("bad channel count on an accepted header");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind wav_header_parser whp_checker u_whp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
